/* design/apq_pkg.sv */
// aging priority queue: shared types and codes
// used by the cell and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_BADPRIO = 2'd3
  } apq_status_t;

  typedef enum logic {
    FUNC_INSERT   = 1'b0,
    FUNC_RETRIEVE = 1'b1
  } apq_func_t;

  // broadcast command to every cell of the chain
  typedef struct packed {
    logic ins;
    logic ret;
  } apq_cmd_t;

endpackage

`default_nettype wire

/* design/apq_if.sv */
// aging priority queue: request and result channel interfaces
// valid/ready handshake; no package dependencies
`timescale 1ns / 1ps
`default_nettype none

interface apq_in_if #(
  parameter int ID_BITS   = 16,
  parameter int PRIO_BITS = 8
);
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [ID_BITS-1:0]   id;
  logic [PRIO_BITS-1:0] priority_req;

  modport source (output valid, func, id, priority_req, input ready);
  modport sink   (input valid, func, id, priority_req, output ready);
endinterface

interface apq_out_if #(
  parameter int ID_BITS = 16,
  parameter int CNT_W   = 5
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] out_id;
  logic [1:0]         status;
  logic [CNT_W-1:0]   occupancy;

  modport source (output valid, out_id, status, occupancy, input ready);
  modport sink   (input valid, out_id, status, occupancy, output ready);
endinterface

`default_nettype wire

/* design/apq_cell.sv */
// aging priority queue: one slot of the sorted chain
// uses apq_pkg::apq_cmd_t; talks only to its two neighbors
`timescale 1ns / 1ps
`default_nettype none

module apq_cell #(
  parameter int ID_BITS   = 16,
  parameter int PRIO_BITS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire apq_pkg::apq_cmd_t    cmd,
  input  wire logic [ID_BITS-1:0]   new_id,
  input  wire logic [PRIO_BITS-1:0] new_prio,
  input  wire logic                 prev_keep,
  input  wire logic                 prev_valid,
  input  wire logic [ID_BITS-1:0]   prev_id,
  input  wire logic [PRIO_BITS-1:0] prev_prio,
  input  wire logic                 next_valid,
  input  wire logic [ID_BITS-1:0]   next_id,
  input  wire logic [PRIO_BITS-1:0] next_prio,
  output logic                      keep,
  output logic                      valid,
  output logic [ID_BITS-1:0]        id,
  output logic [PRIO_BITS-1:0]      prio
);

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [PRIO_BITS-1:0] prio_r, prio_nxt;

  // entry stays put on insert when its number is not greater
  assign keep = valid_r && !(prio_r > new_prio);

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    if (cmd.ins) begin
      if (!keep) begin
        if (prev_keep) begin
          valid_nxt = 1'b1;
          id_nxt    = new_id;
          prio_nxt  = new_prio;
        end else begin
          valid_nxt = prev_valid;
          id_nxt    = prev_id;
          prio_nxt  = prev_prio;
        end
      end
    end else if (cmd.ret) begin
      // shift toward head and age
      valid_nxt = next_valid;
      id_nxt    = next_id;
      prio_nxt  = (next_prio > PRIO_BITS'(1)) ? next_prio - PRIO_BITS'(1) : next_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign id    = id_r;
  assign prio  = prio_r;

endmodule

`default_nettype wire

/* design/aging_priority_queue_top.sv */
// aging priority queue: top level, chain of DEPTH cells plus result register
// uses apq_pkg, apq_in_if, apq_out_if and apq_cell
//
// channel    dir  transaction                         fields
// in_chan    in   one insert or retrieve request      func, id, priority_req
// out_chan   out  one result per request              out_id, status, occupancy
//
// every request is settled in the cycle it is accepted; all cells shift
// or age together, so a new request is taken in every cycle unless a stalled result holds the output register
// the result appears in the output register in the cycle after acceptance
// a stalled result blocks input only while the output register stays full
// synchronous active-low reset empties the chain; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module aging_priority_queue_top #(
  parameter int DEPTH     = 16,
  parameter int ID_BITS   = 16,
  parameter int PRIO_BITS = 8
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  apq_in_if.sink     in_chan,
  apq_out_if.source  out_chan
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                 cell_valid [DEPTH];
  logic [ID_BITS-1:0]   cell_id    [DEPTH];
  logic [PRIO_BITS-1:0] cell_prio  [DEPTH];
  logic                 cell_keep  [DEPTH];

  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 out_valid_r;
  logic [ID_BITS-1:0]   out_id_r, out_id_nxt;
  apq_pkg::apq_status_t status_r, status_nxt;
  logic [CNT_W-1:0]     occ_r;

  logic                 accept;
  apq_pkg::apq_cmd_t    cmd;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  always_comb begin
    cmd        = '0;
    count_nxt  = count_r;
    out_id_nxt = '0;
    status_nxt = apq_pkg::ST_OK;
    if (in_chan.func == apq_pkg::FUNC_INSERT) begin
      if (in_chan.priority_req == '0) begin
        status_nxt = apq_pkg::ST_BADPRIO;
      end else if (count_r == CNT_W'(DEPTH)) begin
        status_nxt = apq_pkg::ST_FULL;
      end else begin
        cmd.ins   = accept;
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (count_r == '0) begin
        status_nxt = apq_pkg::ST_EMPTY;
      end else begin
        cmd.ret    = accept;
        count_nxt  = count_r - CNT_W'(1);
        out_id_nxt = cell_id[0];
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 p_keep, p_valid, n_valid;
    logic [ID_BITS-1:0]   p_id, n_id;
    logic [PRIO_BITS-1:0] p_prio, n_prio;

    if (i == 0) begin : g_first
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_id    = '0;
      assign p_prio  = '0;
    end else begin : g_mid
      assign p_keep  = cell_keep[i-1];
      assign p_valid = cell_valid[i-1];
      assign p_id    = cell_id[i-1];
      assign p_prio  = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_id    = '0;
      assign n_prio  = '0;
    end else begin : g_inner
      assign n_valid = cell_valid[i+1];
      assign n_id    = cell_id[i+1];
      assign n_prio  = cell_prio[i+1];
    end

    apq_cell #(
      .ID_BITS   (ID_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .new_id     (in_chan.id),
      .new_prio   (in_chan.priority_req),
      .prev_keep  (p_keep),
      .prev_valid (p_valid),
      .prev_id    (p_id),
      .prev_prio  (p_prio),
      .next_valid (n_valid),
      .next_id    (n_id),
      .next_prio  (n_prio),
      .keep       (cell_keep[i]),
      .valid      (cell_valid[i]),
      .id         (cell_id[i]),
      .prio       (cell_prio[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_id_r <= out_id_nxt;
      status_r <= status_nxt;
      occ_r    <= count_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_id    = out_id_r;
  assign out_chan.status    = status_r;
  assign out_chan.occupancy = occ_r;

endmodule

`default_nettype wire
